@@ hw/rtl/ffa_pkg.sv @@
// Shared types and constants for the first-fit heap allocator.
// Used by ffa_ctrl, ffa_datapath and first_fit_heap_allocator; depends on nothing.
package ffa_pkg;

    localparam int MAX_BLOCKS   = 64;
    localparam int IDX_W        = $clog2(MAX_BLOCKS);
    localparam int CNT_W        = IDX_W + 1;
    localparam int DATA_W       = 25;
    localparam int HEADER_BYTES = 32;
    localparam int ALIGN_BYTES  = 16;
    localparam int PAGE_BYTES   = 4096;
    localparam int SPLIT_MIN    = 16;
    localparam int ALIGN_SH     = $clog2(ALIGN_BYTES);
    localparam int PAGE_SH      = $clog2(PAGE_BYTES);
    localparam logic [DATA_W-1:0] INIT_RESET = DATA_W'(65536);

    // Operation codes on the input word.
    localparam logic [1:0] OP_INIT  = 2'd0;
    localparam logic [1:0] OP_ALLOC = 2'd1;
    localparam logic [1:0] OP_FREE  = 2'd2;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NULL    = 2'd1,
        ST_NO_MEM  = 2'd2,
        ST_BAD     = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_ACCEPT,
        CMD_INIT,
        CMD_READ_IDX,
        CMD_SCAN_NEXT,
        CMD_LOAD_CUR,
        CMD_UP_START,
        CMD_READ_JM1,
        CMD_WRITE_J_DEC,
        CMD_SPLIT,
        CMD_TAKE,
        CMD_MARK_FREE,
        CMD_READ_NEXT,
        CMD_MERGE_NEXT,
        CMD_READ_JP1,
        CMD_WRITE_J_INC,
        CMD_DEC_COUNT,
        CMD_READ_PREV,
        CMD_MERGE_PREV,
        CMD_WRITE_CUR,
        CMD_DONE
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        status_t status;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic req_zero;
        logic addr_zero;
        logic idx_lt_count;
        logic fit;
        logic match;
        logic split_ok;
        logic cur_free;
        logic up_more;
        logic has_next;
        logic merge_next;
        logic dn_more;
        logic has_prev;
        logic merge_prev;
    } dp_stat_t;

    typedef struct packed {
        logic [DATA_W-1:0] start;
        logic [DATA_W-1:0] usable;
        logic              is_free;
    } entry_t;

endpackage

@@ hw/rtl/ffa_datapath.sv @@
// Datapath of the allocator: block table memory, counters, arithmetic, result word.
// Depends on ffa_pkg; driven by commands from ffa_ctrl.
module ffa_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ffa_pkg::cmd_t             cmd,
    output ffa_pkg::dp_stat_t         stat,
    input  logic                      cfg_wr_en,
    input  logic [ffa_pkg::DATA_W-1:0] cfg_wr_data,
    input  logic [1:0]                op,
    input  logic [ffa_pkg::DATA_W-1:0] request_size,
    input  logic [ffa_pkg::DATA_W-1:0] free_address,
    output logic [1:0]                status,
    output logic [ffa_pkg::DATA_W-1:0] address,
    output logic [ffa_pkg::DATA_W-1:0] allocated_bytes,
    output logic [ffa_pkg::DATA_W-1:0] total_bytes
);
    import ffa_pkg::*;

    localparam logic [DATA_W+1:0] HDR = (DATA_W+2)'(HEADER_BYTES);
    localparam logic [DATA_W+1:0] SAT_TOTAL =
        (DATA_W+2)'(((1 << DATA_W) - 1) / PAGE_BYTES * PAGE_BYTES);

    entry_t mem [MAX_BLOCKS];
    entry_t rd_data_reg;

    logic [DATA_W-1:0] initial_bytes_reg;
    logic [1:0]        op_reg;
    logic [DATA_W:0]   size_reg;
    logic [DATA_W-1:0] faddr_reg;
    logic [CNT_W-1:0]  idx_reg, j_reg, count_reg;
    logic [CNT_W-1:0]  idx_next, j_next, count_next;
    logic [DATA_W-1:0] cur_start_reg, cur_usable_reg;
    logic [DATA_W-1:0] cur_usable_next;
    logic              cur_free_reg, cur_free_next;
    logic [DATA_W-1:0] in_use_reg, in_use_next, total_reg, total_next, addr_next;
    logic [DATA_W-1:0] req_addr_reg;
    logic [DATA_W:0]   size_calc;
    logic [DATA_W+1:0] total_calc;

    logic              rd_en, wr_en;
    logic [CNT_W-1:0]  rd_idx, wr_idx;
    entry_t            wr_data;

    // Request rounding and init arena sizing are shifts and masks.
    always_comb
    begin
        size_calc  = ({1'b0, request_size} + (DATA_W+1)'(ALIGN_BYTES - 1))
                     >> ALIGN_SH << ALIGN_SH;
        total_calc = ({2'b0, initial_bytes_reg} + HDR + (DATA_W+2)'(PAGE_BYTES - 1))
                     >> PAGE_SH << PAGE_SH;
        if (total_calc > (DATA_W+2)'((1 << DATA_W) - 1))
        begin
            total_calc = SAT_TOTAL;
        end
    end

    // Status flags for the controller.
    always_comb
    begin
        stat.op           = op_reg;
        stat.req_zero     = (size_reg == '0);
        stat.addr_zero    = (faddr_reg == '0);
        stat.idx_lt_count = (idx_reg < count_reg);
        stat.fit          = rd_data_reg.is_free && ({1'b0, rd_data_reg.usable} >= size_reg);
        stat.match        = ({1'b0, rd_data_reg.start} + (DATA_W+1)'(HEADER_BYTES))
                            == {1'b0, faddr_reg};
        stat.split_ok     = ({2'b0, cur_usable_reg} >=
                             {1'b0, size_reg} + HDR + (DATA_W+2)'(SPLIT_MIN))
                            && (count_reg < CNT_W'(MAX_BLOCKS));
        stat.cur_free     = cur_free_reg;
        stat.up_more      = ({1'b0, j_reg} > {1'b0, idx_reg} + (CNT_W+1)'(1));
        stat.has_next     = ({1'b0, idx_reg} + (CNT_W+1)'(1) < {1'b0, count_reg});
        stat.merge_next   = rd_data_reg.is_free &&
                            ({2'b0, rd_data_reg.start} ==
                             {2'b0, cur_start_reg} + HDR + {2'b0, cur_usable_reg});
        stat.dn_more      = ({1'b0, j_reg} + (CNT_W+1)'(1) < {1'b0, count_reg});
        stat.has_prev     = (idx_reg != '0);
        stat.merge_prev   = rd_data_reg.is_free &&
                            ({2'b0, cur_start_reg} ==
                             {2'b0, rd_data_reg.start} + HDR + {2'b0, rd_data_reg.usable});
    end

    // Command decode: memory port use and register updates.
    always_comb
    begin
        rd_en           = 1'b0;
        rd_idx          = idx_reg;
        wr_en           = 1'b0;
        wr_idx          = idx_reg;
        wr_data         = '{start: cur_start_reg, usable: cur_usable_reg, is_free: cur_free_reg};
        idx_next        = idx_reg;
        j_next          = j_reg;
        count_next      = count_reg;
        cur_usable_next = cur_usable_reg;
        cur_free_next   = cur_free_reg;
        in_use_next     = in_use_reg;
        total_next      = total_reg;
        addr_next       = req_addr_reg;
        unique case (cmd.op)
            CMD_ACCEPT:
            begin
                idx_next  = '0;
                addr_next = '0;
            end
            CMD_INIT:
            begin
                wr_en       = 1'b1;
                wr_idx      = '0;
                wr_data     = '{start: '0,
                                usable: DATA_W'(total_calc - HDR),
                                is_free: 1'b1};
                count_next  = CNT_W'(1);
                in_use_next = '0;
                total_next  = DATA_W'(total_calc);
            end
            CMD_READ_IDX:
            begin
                rd_en = 1'b1;
            end
            CMD_SCAN_NEXT:
            begin
                idx_next = idx_reg + CNT_W'(1);
            end
            CMD_LOAD_CUR:
            begin
                cur_usable_next = rd_data_reg.usable;
                cur_free_next   = rd_data_reg.is_free;
            end
            CMD_UP_START:
            begin
                j_next = count_reg;
            end
            CMD_READ_JM1:
            begin
                rd_en  = 1'b1;
                rd_idx = j_reg - CNT_W'(1);
            end
            CMD_WRITE_J_DEC:
            begin
                wr_en   = 1'b1;
                wr_idx  = j_reg;
                wr_data = rd_data_reg;
                j_next  = j_reg - CNT_W'(1);
            end
            CMD_SPLIT:
            begin
                wr_en           = 1'b1;
                wr_idx          = idx_reg + CNT_W'(1);
                wr_data         = '{start: DATA_W'({2'b0, cur_start_reg} + HDR
                                                   + {1'b0, size_reg}),
                                    usable: DATA_W'({2'b0, cur_usable_reg}
                                                    - {1'b0, size_reg} - HDR),
                                    is_free: 1'b1};
                cur_usable_next = DATA_W'(size_reg);
                count_next      = count_reg + CNT_W'(1);
            end
            CMD_TAKE:
            begin
                wr_en       = 1'b1;
                wr_data     = '{start: cur_start_reg, usable: cur_usable_reg, is_free: 1'b0};
                in_use_next = in_use_reg + cur_usable_reg;
                addr_next   = DATA_W'({2'b0, cur_start_reg} + HDR);
            end
            CMD_MARK_FREE:
            begin
                cur_free_next = 1'b1;
                in_use_next   = in_use_reg - cur_usable_reg;
            end
            CMD_READ_NEXT:
            begin
                rd_en  = 1'b1;
                rd_idx = idx_reg + CNT_W'(1);
            end
            CMD_MERGE_NEXT:
            begin
                cur_usable_next = DATA_W'({2'b0, cur_usable_reg} + HDR
                                          + {2'b0, rd_data_reg.usable});
                j_next          = idx_reg + CNT_W'(1);
            end
            CMD_READ_JP1:
            begin
                rd_en  = 1'b1;
                rd_idx = j_reg + CNT_W'(1);
            end
            CMD_WRITE_J_INC:
            begin
                wr_en   = 1'b1;
                wr_idx  = j_reg;
                wr_data = rd_data_reg;
                j_next  = j_reg + CNT_W'(1);
            end
            CMD_DEC_COUNT:
            begin
                count_next = count_reg - CNT_W'(1);
            end
            CMD_READ_PREV:
            begin
                rd_en  = 1'b1;
                rd_idx = idx_reg - CNT_W'(1);
            end
            CMD_MERGE_PREV:
            begin
                wr_en   = 1'b1;
                wr_idx  = idx_reg - CNT_W'(1);
                wr_data = '{start: rd_data_reg.start,
                            usable: DATA_W'({2'b0, rd_data_reg.usable} + HDR
                                            + {2'b0, cur_usable_reg}),
                            is_free: 1'b1};
                j_next  = idx_reg;
            end
            CMD_WRITE_CUR:
            begin
                wr_en = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Block table memory with registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx[IDX_W-1:0]] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx[IDX_W-1:0]];
        end
    end

    // Control and bookkeeping registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            initial_bytes_reg <= INIT_RESET;
            count_reg         <= '0;
            in_use_reg        <= '0;
            total_reg         <= '0;
            idx_reg           <= '0;
            j_reg             <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                initial_bytes_reg <= cfg_wr_data;
            end
            count_reg  <= count_next;
            in_use_reg <= in_use_next;
            total_reg  <= total_next;
            idx_reg    <= idx_next;
            j_reg      <= j_next;
        end
    end

    // Payload registers: latched word, current block and result word.
    always_ff @(posedge clk)
    begin
        if (cmd.op == CMD_ACCEPT)
        begin
            op_reg    <= op;
            size_reg  <= size_calc;
            faddr_reg <= free_address;
        end
        if (cmd.op == CMD_LOAD_CUR)
        begin
            cur_start_reg <= rd_data_reg.start;
        end
        cur_usable_reg <= cur_usable_next;
        cur_free_reg   <= cur_free_next;
        req_addr_reg   <= addr_next;
        if (cmd.op == CMD_DONE)
        begin
            status          <= cmd.status;
            address         <= req_addr_reg;
            allocated_bytes <= in_use_reg;
            total_bytes     <= total_reg;
        end
    end

endmodule

@@ hw/rtl/ffa_ctrl.sv @@
// Controller state machine of the allocator: sequences scans, shifts and merges.
// Depends on ffa_pkg; commands ffa_datapath and owns the channel handshakes.
module ffa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  ffa_pkg::dp_stat_t stat,
    output ffa_pkg::cmd_t     cmd
);
    import ffa_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_A_DECIDE,
        S_UP_TEST,
        S_UP_WR,
        S_A_TAKE,
        S_F_CHECK,
        S_F_NEXT,
        S_F_NEXT_CHK,
        S_DN_TEST,
        S_DN_WR,
        S_F_PREV,
        S_F_PREV_CHK,
        S_FINISH
    } state_t;

    state_t  state_reg, state_next;
    status_t status_reg, status_next;
    logic    last_drop_reg, last_drop_next;
    logic    out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and command for the datapath.
    always_comb
    begin
        state_next     = state_reg;
        status_next    = status_reg;
        last_drop_next = last_drop_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = CMD_NONE;
        cmd.status     = status_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = CMD_ACCEPT;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_FINISH;
                case (stat.op)
                    OP_INIT:
                    begin
                        cmd.op      = CMD_INIT;
                        status_next = ST_OK;
                    end
                    OP_ALLOC:
                    begin
                        status_next = stat.req_zero ? ST_NULL : ST_NO_MEM;
                        if (!stat.req_zero)
                        begin
                            state_next = S_SCAN_RD;
                        end
                    end
                    OP_FREE:
                    begin
                        status_next = stat.addr_zero ? ST_NULL : ST_BAD;
                        if (!stat.addr_zero)
                        begin
                            state_next = S_SCAN_RD;
                        end
                    end
                    default:
                    begin
                        status_next = ST_NULL;
                    end
                endcase
            end
            S_SCAN_RD:
            begin
                if (stat.idx_lt_count)
                begin
                    cmd.op     = CMD_READ_IDX;
                    state_next = S_SCAN_CHK;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_SCAN_CHK:
            begin
                if ((stat.op == OP_ALLOC) ? stat.fit : stat.match)
                begin
                    cmd.op     = CMD_LOAD_CUR;
                    state_next = (stat.op == OP_ALLOC) ? S_A_DECIDE : S_F_CHECK;
                end
                else
                begin
                    cmd.op     = CMD_SCAN_NEXT;
                    state_next = S_SCAN_RD;
                end
            end
            S_A_DECIDE:
            begin
                status_next = ST_OK;
                if (stat.split_ok)
                begin
                    cmd.op     = CMD_UP_START;
                    state_next = S_UP_TEST;
                end
                else
                begin
                    cmd.op     = CMD_TAKE;
                    state_next = S_FINISH;
                end
            end
            S_UP_TEST:
            begin
                if (stat.up_more)
                begin
                    cmd.op     = CMD_READ_JM1;
                    state_next = S_UP_WR;
                end
                else
                begin
                    cmd.op     = CMD_SPLIT;
                    state_next = S_A_TAKE;
                end
            end
            S_UP_WR:
            begin
                cmd.op     = CMD_WRITE_J_DEC;
                state_next = S_UP_TEST;
            end
            S_A_TAKE:
            begin
                cmd.op     = CMD_TAKE;
                state_next = S_FINISH;
            end
            S_F_CHECK:
            begin
                if (stat.cur_free)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.op         = CMD_MARK_FREE;
                    status_next    = ST_OK;
                    last_drop_next = 1'b0;
                    state_next     = S_F_NEXT;
                end
            end
            S_F_NEXT:
            begin
                if (stat.has_next)
                begin
                    cmd.op     = CMD_READ_NEXT;
                    state_next = S_F_NEXT_CHK;
                end
                else
                begin
                    state_next = S_F_PREV;
                end
            end
            S_F_NEXT_CHK:
            begin
                if (stat.merge_next)
                begin
                    cmd.op     = CMD_MERGE_NEXT;
                    state_next = S_DN_TEST;
                end
                else
                begin
                    state_next = S_F_PREV;
                end
            end
            S_DN_TEST:
            begin
                if (stat.dn_more)
                begin
                    cmd.op     = CMD_READ_JP1;
                    state_next = S_DN_WR;
                end
                else
                begin
                    cmd.op     = CMD_DEC_COUNT;
                    state_next = last_drop_reg ? S_FINISH : S_F_PREV;
                end
            end
            S_DN_WR:
            begin
                cmd.op     = CMD_WRITE_J_INC;
                state_next = S_DN_TEST;
            end
            S_F_PREV:
            begin
                if (stat.has_prev)
                begin
                    cmd.op     = CMD_READ_PREV;
                    state_next = S_F_PREV_CHK;
                end
                else
                begin
                    cmd.op     = CMD_WRITE_CUR;
                    state_next = S_FINISH;
                end
            end
            S_F_PREV_CHK:
            begin
                if (stat.merge_prev)
                begin
                    cmd.op         = CMD_MERGE_PREV;
                    last_drop_next = 1'b1;
                    state_next     = S_DN_TEST;
                end
                else
                begin
                    cmd.op     = CMD_WRITE_CUR;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                // Load the result register once the previous word has left.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = CMD_DONE;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered handshake outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            status_reg    <= ST_OK;
            last_drop_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            status_reg    <= status_next;
            last_drop_reg <= last_drop_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ hw/rtl/first_fit_heap_allocator.sv @@
// First-fit heap allocator top level: controller plus datapath.
// Depends on ffa_pkg, ffa_ctrl and ffa_datapath.
//
// Input words (op, request_size, free_address) are taken on in_valid/in_ready;
// each word gives one result word (status, address, allocated_bytes,
// total_bytes) on out_valid/out_ready. One word is worked on at a time.
// Init and null or zero requests go straight from dispatch to the result.
// Allocate and free scan the block table entry by entry, each entry read
// from the registered memory and then checked, and may then shift entries,
// each one read and then written, to open or close a slot.
// The result sits in an output register; the next input word is accepted
// while it waits, and the block stalls only when a second result is ready
// before the first was taken.
// The arena register is written through cfg_wr_en/cfg_wr_data; the user is
// to write it only while idle, which the block itself leaves unchecked.
// Reset empties the table (no blocks, zero totals) and sets the arena
// request to 65536 bytes; allocates before an init report out of memory.
module first_fit_heap_allocator (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [ffa_pkg::DATA_W-1:0] cfg_wr_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 op,
    input  logic [ffa_pkg::DATA_W-1:0] request_size,
    input  logic [ffa_pkg::DATA_W-1:0] free_address,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [1:0]                 status,
    output logic [ffa_pkg::DATA_W-1:0] address,
    output logic [ffa_pkg::DATA_W-1:0] allocated_bytes,
    output logic [ffa_pkg::DATA_W-1:0] total_bytes
);
    import ffa_pkg::*;

    cmd_t     cmd;
    dp_stat_t stat;

    // Sequencer.
    ffa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Table, arithmetic and result register.
    ffa_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .op              (op),
        .request_size    (request_size),
        .free_address    (free_address),
        .status          (status),
        .address         (address),
        .allocated_bytes (allocated_bytes),
        .total_bytes     (total_bytes)
    );

endmodule
